### hdl/sdst_pkg.sv
// Shared types and codes of the sorted disjoint span table.
// Entry record, request and result layouts, action codes.
// No dependencies.
package sdst_pkg;

    localparam logic [2:0] ACT_ADD_STYLE = 3'd0;
    localparam logic [2:0] ACT_ADD_PRES  = 3'd1;
    localparam logic [2:0] ACT_READ      = 3'd2;
    localparam logic [2:0] ACT_QUERY     = 3'd3;
    localparam logic [2:0] ACT_CLEAR     = 3'd4;

    localparam int IN_DATA_W  = 272;
    localparam int OUT_DATA_W = 304;

    // One stored range with its style and presentation
    typedef struct packed {
        logic [63:0] pval;
        logic [31:0] ptype;
        logic [7:0]  flags;
        logic [31:0] bg;
        logic [31:0] fg;
        logic [31:0] stop;
        logic [31:0] start;
    } entry_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] start;
        logic [31:0] stop;
        logic [31:0] fg;
        logic [31:0] bg;
        logic [7:0]  flags;
        logic [31:0] ptype;
        logic [63:0] pval;
        logic [4:0]  index;
        logic [31:0] qpos;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic        rel_valid;
        logic [63:0] rel_value;
        entry_t      ent;
        logic [5:0]  count;
        logic        last;
    } res_t;

    // Result with every field zero but the count, closing its run
    function automatic res_t res_blank(logic [5:0] cnt);
        res_t r;
        r       = '0;
        r.count = cnt;
        r.last  = 1'b1;
        return r;
    endfunction

endpackage

### hdl/sorted_disjoint_span_table.sv
// Sorted disjoint span table, top level.
// Depends on sdst_pkg, sdst_mem, sdst_ctrl and sdst_out.
//
// Requests arrive on the s_ group, one action per transfer (tuser holds the
// action code). Results leave on the m_ group, and tlast marks the final
// result of a request. Add, read, query and unused codes give one result
// each. Clear gives one result per presented entry released, or one bare result.
// One request is worked on at a time; s_tready is high only while idle.
// Cycles from an accepting edge until the next request can be taken, with n
// stored entries and slot s of the new range:
//   add: up to n + 4 for the slot search and decision; a new entry adds
//   n - s + 4 for shifting, insert and result (3 when appending), while a
//   merge or reject adds 1; read: 3; point query: up to n + 5;
//   clear: 2n + 3, plus 1 per released value after the first,
//   plus receiver stalls.
// These figures come from the single read port of the entry store. The
// search, shift and clear walks share that port and move one entry a cycle.
// Results pass through an output register, so a new request is taken while
// the last result waits. A stalled receiver holds the sequencer only when
// it has the next result ready. Reset empties the table at once; the store
// contents are left as they are and never read before written.
module sorted_disjoint_span_table
    import sdst_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // span_start, span_end, style_fg, style_bg, style_flags, pres_type,
    // pres_value, entry_index, query_pos, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // action
    input  logic [2:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // released_value, entry_start, entry_stop, entry_fg, entry_bg,
    // entry_flags, entry_type, entry_value, stored_count, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // ok, released_valid
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    req_t          req;
    logic          re;
    logic          we;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    entry_t        rdata;
    entry_t        wdata;
    logic          emit;
    logic          out_free;
    res_t          res_c;
    res_t          res_o;

    // Unpack the request transfer
    always_comb
    begin
        req.action = s_tuser;
        req.start  = s_tdata[31:0];
        req.stop   = s_tdata[63:32];
        req.fg     = s_tdata[95:64];
        req.bg     = s_tdata[127:96];
        req.flags  = s_tdata[135:128];
        req.ptype  = s_tdata[167:136];
        req.pval   = s_tdata[231:168];
        req.index  = s_tdata[236:232];
        req.qpos   = s_tdata[268:237];
    end

    sdst_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .clk   (clk),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata)
    );

    sdst_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .req      (req),
        .re       (re),
        .raddr    (raddr),
        .rdata    (rdata),
        .we       (we),
        .waddr    (waddr),
        .wdata    (wdata),
        .emit     (emit),
        .res      (res_c),
        .out_free (out_free)
    );

    sdst_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .res_in    (res_c),
        .free      (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res_out   (res_o)
    );

    // Pack the result transfer
    assign m_tdata = {2'b00, res_o.count, res_o.ent.pval, res_o.ent.ptype, res_o.ent.flags,
                      res_o.ent.bg, res_o.ent.fg, res_o.ent.stop, res_o.ent.start,
                      res_o.rel_value};
    assign m_tuser = {res_o.rel_valid, res_o.ok};
    assign m_tlast = res_o.last;

endmodule

### hdl/sdst_mem.sv
// Entry store: single write port, single read port, registered read data.
// Depends on sdst_pkg for the entry record.
module sdst_mem
    import sdst_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata
);

    entry_t mem [DEPTH];

    // Write and read in one clocked block
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/sdst_out.sv
// Output register stage for result transfers.
// Depends on sdst_pkg for the result layout.
module sdst_out
    import sdst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  res_t res_in,
    output logic free,
    output logic out_valid,
    input  logic out_ready,
    output res_t res_out
);

    logic valid_reg;
    res_t res_reg;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

endmodule

### hdl/sdst_ctrl.sv
// Sequencer of the span table: slot search, entry shifting, merge,
// read, point query and clear over the entry store.
// Depends on sdst_pkg.
module sdst_ctrl
    import sdst_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  req_t          req,
    output logic          re,
    output logic [AW-1:0] raddr,
    input  entry_t        rdata,
    output logic          we,
    output logic [AW-1:0] waddr,
    output entry_t        wdata,
    output logic          emit,
    output res_t          res,
    input  logic          out_free
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SEARCH = 9'b000000010,
        S_DECIDE = 9'b000000100,
        S_SHIFT  = 9'b000001000,
        S_INSERT = 9'b000010000,
        S_RDWAIT = 9'b000100000,
        S_CLR    = 9'b001000000,
        S_CLRCHK = 9'b010000000,
        S_EMIT   = 9'b100000000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    req_t          req_reg, req_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_idx_reg, pend_idx_next;
    logic          prev_valid_reg, prev_valid_next;
    logic [31:0]   prev_end_reg, prev_end_next;
    logic          cur_valid_reg, cur_valid_next;
    entry_t        cur_reg, cur_next;
    logic [CW-1:0] slot_reg, slot_next;
    logic [CW-1:0] sh_left_reg, sh_left_next;
    logic [AW-1:0] sh_addr_reg, sh_addr_next;
    logic [CW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0] clr_idx_reg, clr_idx_next;
    logic          held_valid_reg, held_valid_next;
    logic [63:0]   held_val_reg, held_val_next;
    logic          ret_clr_reg, ret_clr_next;
    res_t          res_reg, res_next;

    logic   is_query;
    logic   found;
    logic   ident;
    logic   ovl;
    entry_t merged;
    entry_t fresh;

    assign in_ready = (state_reg == S_IDLE);
    assign res      = res_reg;
    assign is_query = (req_reg.action == ACT_QUERY);

    // Stop condition of the scan: covering presented entry, or first start not below
    always_comb
    begin
        if (is_query)
        begin
            found = pend_reg && (rdata.ptype != 32'd0) && (rdata.start <= req_reg.qpos)
                    && (req_reg.qpos < rdata.stop);
        end
        else
        begin
            found = pend_reg && !(rdata.start < req_reg.start);
        end
    end

    // Slot classification and the records to write
    always_comb
    begin
        ident = cur_valid_reg && (cur_reg.start == req_reg.start)
                && (cur_reg.stop == req_reg.stop);
        ovl   = (prev_valid_reg && (prev_end_reg > req_reg.start))
                || (cur_valid_reg && (cur_reg.start < req_reg.stop));
        merged = cur_reg;
        if (req_reg.action == ACT_ADD_STYLE)
        begin
            if (req_reg.flags[0])
            begin
                merged.fg = req_reg.fg;
            end
            if (req_reg.flags[1])
            begin
                merged.bg = req_reg.bg;
            end
            merged.flags = cur_reg.flags | req_reg.flags;
        end
        else
        begin
            merged.ptype = req_reg.ptype;
            merged.pval  = req_reg.pval;
        end
        fresh       = '0;
        fresh.start = req_reg.start;
        fresh.stop  = req_reg.stop;
        if (req_reg.action == ACT_ADD_STYLE)
        begin
            fresh.fg    = req_reg.fg;
            fresh.bg    = req_reg.bg;
            fresh.flags = req_reg.flags;
        end
        else
        begin
            fresh.ptype = req_reg.ptype;
            fresh.pval  = req_reg.pval;
        end
    end

    // Next state of the sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        req_next        = req_reg;
        rd_idx_next     = rd_idx_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        prev_valid_next = prev_valid_reg;
        prev_end_next   = prev_end_reg;
        cur_valid_next  = cur_valid_reg;
        cur_next        = cur_reg;
        slot_next       = slot_reg;
        sh_left_next    = sh_left_reg;
        sh_addr_next    = sh_addr_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_idx_next    = clr_idx_reg;
        held_valid_next = held_valid_reg;
        held_val_next   = held_val_reg;
        ret_clr_next    = ret_clr_reg;
        res_next        = res_reg;
        re              = 1'b0;
        raddr           = '0;
        we              = 1'b0;
        waddr           = '0;
        wdata           = merged;
        emit            = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next     = req;
                    res_next     = res_blank(6'(count_reg));
                    ret_clr_next = 1'b0;
                    rd_idx_next  = '0;
                    pend_next    = 1'b0;
                    prev_valid_next = 1'b0;
                    case (req.action)
                        ACT_ADD_STYLE, ACT_ADD_PRES:
                        begin
                            if ((req.start < req.stop)
                                && ((req.action == ACT_ADD_STYLE) || (req.ptype != 32'd0)))
                            begin
                                state_next = S_SEARCH;
                            end
                            else
                            begin
                                state_next = S_EMIT;
                            end
                        end
                        ACT_READ:
                        begin
                            if (7'(req.index) < 7'(count_reg))
                            begin
                                re         = 1'b1;
                                raddr      = AW'(req.index);
                                state_next = S_RDWAIT;
                            end
                            else
                            begin
                                state_next = S_EMIT;
                            end
                        end
                        ACT_QUERY:
                        begin
                            state_next = S_SEARCH;
                        end
                        ACT_CLEAR:
                        begin
                            clr_cnt_next    = count_reg;
                            count_next      = '0;
                            clr_idx_next    = '0;
                            held_valid_next = 1'b0;
                            state_next      = S_CLR;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                // Check the entry read last cycle, issue the next read
                if (found)
                begin
                    cur_next       = rdata;
                    cur_valid_next = 1'b1;
                    slot_next      = CW'(pend_idx_reg);
                    pend_next      = 1'b0;
                    state_next     = S_DECIDE;
                end
                else
                begin
                    if (pend_reg && !is_query)
                    begin
                        prev_end_next   = rdata.stop;
                        prev_valid_next = 1'b1;
                    end
                    if (rd_idx_reg < count_reg)
                    begin
                        re            = 1'b1;
                        raddr         = rd_idx_reg[AW-1:0];
                        pend_next     = 1'b1;
                        pend_idx_next = rd_idx_reg[AW-1:0];
                        rd_idx_next   = rd_idx_reg + CW'(1);
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        if (!pend_reg)
                        begin
                            cur_valid_next = 1'b0;
                            slot_next      = count_reg;
                            state_next     = S_DECIDE;
                        end
                    end
                end
            end
            S_DECIDE:
            begin
                res_next = res_blank(6'(count_reg));
                if (is_query)
                begin
                    if (cur_valid_reg)
                    begin
                        res_next.ok        = 1'b1;
                        res_next.ent.start = cur_reg.start;
                        res_next.ent.stop  = cur_reg.stop;
                        res_next.ent.ptype = cur_reg.ptype;
                        res_next.ent.pval  = cur_reg.pval;
                    end
                    state_next = S_EMIT;
                end
                else if (ident)
                begin
                    we          = 1'b1;
                    waddr       = slot_reg[AW-1:0];
                    wdata       = merged;
                    res_next.ok = 1'b1;
                    if ((req_reg.action == ACT_ADD_PRES) && (cur_reg.ptype != 32'd0))
                    begin
                        res_next.rel_valid = 1'b1;
                        res_next.rel_value = cur_reg.pval;
                    end
                    state_next = S_EMIT;
                end
                else if (ovl || (count_reg >= CW'(DEPTH)))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    sh_left_next = count_reg - slot_reg;
                    sh_addr_next = AW'(count_reg - CW'(1));
                    pend_next    = 1'b0;
                    state_next   = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                // Move entries up by one, top first
                if (pend_reg)
                begin
                    we    = 1'b1;
                    waddr = pend_idx_reg + AW'(1);
                    wdata = rdata;
                end
                if (sh_left_reg != '0)
                begin
                    re            = 1'b1;
                    raddr         = sh_addr_reg;
                    pend_next     = 1'b1;
                    pend_idx_next = sh_addr_reg;
                    sh_addr_next  = sh_addr_reg - AW'(1);
                    sh_left_next  = sh_left_reg - CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_INSERT;
                    end
                end
            end
            S_INSERT:
            begin
                we          = 1'b1;
                waddr       = slot_reg[AW-1:0];
                wdata       = fresh;
                count_next  = count_reg + CW'(1);
                res_next    = res_blank(6'(count_reg + CW'(1)));
                res_next.ok = 1'b1;
                state_next  = S_EMIT;
            end
            S_RDWAIT:
            begin
                res_next     = res_blank(6'(count_reg));
                res_next.ok  = 1'b1;
                res_next.ent = rdata;
                state_next   = S_EMIT;
            end
            S_CLR:
            begin
                if (clr_idx_reg < clr_cnt_reg)
                begin
                    re           = 1'b1;
                    raddr        = clr_idx_reg[AW-1:0];
                    clr_idx_next = clr_idx_reg + CW'(1);
                    state_next   = S_CLRCHK;
                end
                else
                begin
                    // Close the run with the held value, or a bare result
                    res_next           = res_blank(6'd0);
                    res_next.ok        = 1'b1;
                    res_next.rel_valid = held_valid_reg;
                    res_next.rel_value = held_valid_reg ? held_val_reg : 64'd0;
                    ret_clr_next       = 1'b0;
                    state_next         = S_EMIT;
                end
            end
            S_CLRCHK:
            begin
                state_next = S_CLR;
                if (rdata.ptype != 32'd0)
                begin
                    held_val_next   = rdata.pval;
                    held_valid_next = 1'b1;
                    if (held_valid_reg)
                    begin
                        res_next           = res_blank(6'd0);
                        res_next.ok        = 1'b1;
                        res_next.rel_valid = 1'b1;
                        res_next.rel_value = held_val_reg;
                        res_next.last      = 1'b0;
                        ret_clr_next       = 1'b1;
                        state_next         = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ret_clr_reg ? S_CLR : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_reg       <= 1'b0;
            ret_clr_reg    <= 1'b0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_reg       <= pend_next;
            ret_clr_reg    <= ret_clr_next;
            held_valid_reg <= held_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        rd_idx_reg     <= rd_idx_next;
        pend_idx_reg   <= pend_idx_next;
        prev_valid_reg <= prev_valid_next;
        prev_end_reg   <= prev_end_next;
        cur_valid_reg  <= cur_valid_next;
        cur_reg        <= cur_next;
        slot_reg       <= slot_next;
        sh_left_reg    <= sh_left_next;
        sh_addr_reg    <= sh_addr_next;
        clr_cnt_reg    <= clr_cnt_next;
        clr_idx_reg    <= clr_idx_next;
        held_val_reg   <= held_val_next;
        res_reg        <= res_next;
    end

endmodule

### tb/sorted_disjoint_span_table_check.sv
// Scoreboard for the sorted disjoint span table: watches both stream channels,
// predicts every result from the accepted requests and compares them in order.
// Depends on sdst_pkg for the request and result layouts and the action codes.
module sorted_disjoint_span_table_check
    import sdst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [2:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [1:0]            m_tuser,
    input  logic                  m_tlast,
    output int                    errors,
    output int                    pending,
    output int                    results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 32;

    // Shadow copy of the table
    entry_t     table_q [SLOTS];
    int         stored;
    res_t       awaited [$];

    assign pending = awaited.size();

    // Work out the results of one request and update the shadow table
    function automatic void predict_spans(req_t rq);
        res_t r;
        int   i;
        int   k;
        int   hits;
        bit   good;
        entry_t e;
        r = '0;
        if (rq.action == ACT_ADD_STYLE || rq.action == ACT_ADD_PRES) begin
            good = rq.start < rq.stop && (rq.action == ACT_ADD_STYLE || rq.ptype != 0);
            if (good) begin
                i = 0;
                while (i < stored && table_q[i].start < rq.start)
                    i++;
                if (i < stored && table_q[i].start == rq.start && table_q[i].stop == rq.stop) begin
                    // merge into the identical range
                    if (rq.action == ACT_ADD_STYLE) begin
                        if (rq.flags[0]) table_q[i].fg = rq.fg;
                        if (rq.flags[1]) table_q[i].bg = rq.bg;
                        table_q[i].flags |= rq.flags;
                    end
                    else begin
                        if (table_q[i].ptype != 0) begin
                            r.rel_valid = 1'b1;
                            r.rel_value = table_q[i].pval;
                        end
                        table_q[i].ptype = rq.ptype;
                        table_q[i].pval  = rq.pval;
                    end
                end
                else if ((i > 0 && table_q[i-1].stop > rq.start)
                         || (i < stored && table_q[i].start < rq.stop)
                         || stored >= SLOTS) begin
                    good = 1'b0;
                end
                else begin
                    e = '0;
                    e.start = rq.start;
                    e.stop  = rq.stop;
                    if (rq.action == ACT_ADD_STYLE) begin
                        e.fg    = rq.fg;
                        e.bg    = rq.bg;
                        e.flags = rq.flags;
                    end
                    else begin
                        e.ptype = rq.ptype;
                        e.pval  = rq.pval;
                    end
                    for (k = stored; k > i; k--)
                        table_q[k] = table_q[k-1];
                    table_q[i] = e;
                    stored++;
                end
            end
            r.ok = good;
        end
        else if (rq.action == ACT_READ) begin
            if (rq.index < stored) begin
                r.ok  = 1'b1;
                r.ent = table_q[rq.index];
            end
        end
        else if (rq.action == ACT_QUERY) begin
            for (i = 0; i < stored; i++) begin
                if (!r.ok && table_q[i].ptype != 0 && table_q[i].start <= rq.qpos
                    && rq.qpos < table_q[i].stop) begin
                    r.ok        = 1'b1;
                    r.ent.start = table_q[i].start;
                    r.ent.stop  = table_q[i].stop;
                    r.ent.ptype = table_q[i].ptype;
                    r.ent.pval  = table_q[i].pval;
                end
            end
        end
        else if (rq.action == ACT_CLEAR) begin
            hits = 0;
            for (i = 0; i < stored; i++) begin
                if (table_q[i].ptype != 0) begin
                    r           = '0;
                    r.ok        = 1'b1;
                    r.rel_valid = 1'b1;
                    r.rel_value = table_q[i].pval;
                    awaited.push_back(r);
                    hits++;
                end
            end
            stored = 0;
            if (hits == 0) begin
                r    = '0;
                r.ok = 1'b1;
                awaited.push_back(r);
            end
            awaited[awaited.size()-1].last = 1'b1;
            return;
        end
        r.count = stored[5:0];
        r.last  = 1'b1;
        awaited.push_back(r);
    endfunction

    // Sample requests and results on each edge
    always @(posedge clk or negedge rst_n)
    begin
        req_t rq;
        res_t got;
        res_t want;
        if (!rst_n) begin
            stored  = 0;
            errors  = 0;
            results = 0;
            awaited.delete();
        end
        else begin
            if (s_tvalid && s_tready) begin
                rq.action = s_tuser;
                rq.start  = s_tdata[31:0];
                rq.stop   = s_tdata[63:32];
                rq.fg     = s_tdata[95:64];
                rq.bg     = s_tdata[127:96];
                rq.flags  = s_tdata[135:128];
                rq.ptype  = s_tdata[167:136];
                rq.pval   = s_tdata[231:168];
                rq.index  = s_tdata[236:232];
                rq.qpos   = s_tdata[268:237];
                predict_spans(rq);
            end
            if (m_tvalid && m_tready) begin
                got.ok        = m_tuser[0];
                got.rel_valid = m_tuser[1];
                got.rel_value = m_tdata[63:0];
                got.ent.start = m_tdata[95:64];
                got.ent.stop  = m_tdata[127:96];
                got.ent.fg    = m_tdata[159:128];
                got.ent.bg    = m_tdata[191:160];
                got.ent.flags = m_tdata[199:192];
                got.ent.ptype = m_tdata[231:200];
                got.ent.pval  = m_tdata[295:232];
                got.count     = m_tdata[301:296];
                got.last      = m_tlast;
                results++;
                if (awaited.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: unexpected result ok=%b rel=%b cnt=%0d",
                                 got.ok, got.rel_valid, got.count);
                end
                else begin
                    want = awaited.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch at result %0d", results);
                            $display("  want ok=%b rel=%b/%h cnt=%0d last=%b",
                                     want.ok, want.rel_valid, want.rel_value,
                                     want.count, want.last);
                            $display("  got  ok=%b rel=%b/%h cnt=%0d last=%b",
                                     got.ok, got.rel_valid, got.rel_value,
                                     got.count, got.last);
                            $display("  want entry %h", want.ent);
                            $display("  got  entry %h", got.ent);
                        end
                    end
                end
            end
        end
    end

endmodule

### tb/sorted_disjoint_span_table_test.sv
// Testbench top for the sorted disjoint span table: clock, reset, request
// stimulus, result back-pressure and verdict. Depends on sdst_pkg, the block
// and sorted_disjoint_span_table_check.
module sorted_disjoint_span_table_test;
    import sdst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [2:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    int                    errors;
    int                    pending;
    int                    results;
    int                    sent;
    int                    quiet_cycles;
    bit                    calm;
    logic [31:0]           region;

    sorted_disjoint_span_table uut (.*);

    sorted_disjoint_span_table_check checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stall the result side now and then
    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(0, 99) >= 11);
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL sorted_disjoint_span_table");
            $finish;
        end
    end

    // Hand one request over and hold it until taken
    task automatic send_req(req_t rq);
        s_tvalid <= 1'b1;
        s_tuser  <= rq.action;
        s_tdata  <= {3'b0, rq.qpos, rq.index, rq.pval, rq.ptype, rq.flags,
                     rq.bg, rq.fg, rq.stop, rq.start};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
        if (!calm && $urandom_range(0, 99) < 11) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    function automatic req_t noise_req();
        req_t rq;
        rq.action = 3'($urandom);
        rq.start  = $urandom;
        rq.stop   = $urandom;
        rq.fg     = $urandom;
        rq.bg     = $urandom;
        rq.flags  = 8'($urandom);
        rq.ptype  = $urandom;
        rq.pval   = {$urandom, $urandom};
        rq.index  = 5'($urandom);
        rq.qpos   = $urandom;
        return rq;
    endfunction

    function automatic req_t span_req(logic [2:0] act, logic [31:0] lo, logic [31:0] hi);
        req_t rq;
        rq        = noise_req();
        rq.action = act;
        rq.start  = lo;
        rq.stop   = hi;
        return rq;
    endfunction

    // Mostly well-formed requests on a grid so that merges and overlaps occur
    function automatic req_t random_req();
        req_t rq;
        int   pick;
        logic [31:0] lo;
        pick = $urandom_range(0, 99);
        lo   = region + 32'($urandom_range(0, 63) * 16);
        rq   = span_req(ACT_ADD_STYLE, lo, lo + ($urandom_range(0, 3) == 0
                        ? 32'($urandom_range(1, 40)) : 32'd16));
        if (pick < 35)
            rq.action = ACT_ADD_STYLE;
        else if (pick < 65) begin
            rq.action = ACT_ADD_PRES;
            if ($urandom_range(0, 19) == 0)
                rq.ptype = 0;
        end
        else if (pick < 75)
            rq.action = ACT_READ;
        else if (pick < 88) begin
            rq.action = ACT_QUERY;
            rq.qpos   = region + 32'($urandom_range(0, 1100));
        end
        else if (pick < 91)
            rq.action = ACT_CLEAR;
        else if (pick < 94)
            rq.action = 3'($urandom_range(5, 7));
        else
            rq = noise_req();
        return rq;
    endfunction

    initial
    begin
        req_t rq;
        int   n;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        calm     = 1'b0;
        sent     = 0;
        quiet_cycles = 0;
        region   = 0;
        rst_n    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, extremes, merges, overlaps, release, clears
        rq = span_req(ACT_READ, 0, 0);            rq.index = 0; send_req(rq);
        rq = span_req(ACT_QUERY, 0, 0);           send_req(rq);
        send_req(span_req(ACT_ADD_STYLE, 5, 5));
        send_req(span_req(ACT_ADD_STYLE, 10, 5));
        rq = span_req(ACT_ADD_STYLE, 0, 32'hFFFF_FFFF);
        rq.flags = 8'hFC;                         send_req(rq);
        rq = span_req(ACT_ADD_PRES, 0, 32'hFFFF_FFFF);
        rq.ptype = 0;                             send_req(rq);
        rq = span_req(ACT_ADD_PRES, 0, 32'hFFFF_FFFF);
        rq.ptype = 32'hFFFF_FFFF; rq.pval = '1;   send_req(rq);
        rq = span_req(ACT_ADD_PRES, 0, 32'hFFFF_FFFF);
        rq.ptype = 1;                             send_req(rq);
        rq = span_req(ACT_QUERY, 0, 0);  rq.qpos = 32'hFFFF_FFFE; send_req(rq);
        rq = span_req(ACT_QUERY, 0, 0);  rq.qpos = 32'hFFFF_FFFF; send_req(rq);
        rq = span_req(ACT_ADD_STYLE, 0, 32'hFFFF_FFFF); rq.flags = 8'h01; send_req(rq);
        rq = span_req(ACT_ADD_STYLE, 0, 32'hFFFF_FFFF); rq.flags = 8'h02; send_req(rq);
        rq = span_req(ACT_READ, 0, 0);            rq.index = 0; send_req(rq);
        send_req(span_req(ACT_ADD_STYLE, 5, 10));
        send_req(span_req(ACT_CLEAR, 0, 0));
        send_req(span_req(ACT_CLEAR, 0, 0));
        send_req(span_req(ACT_ADD_STYLE, 100, 200));
        send_req(span_req(ACT_ADD_STYLE, 200, 300));
        rq = span_req(ACT_ADD_PRES, 50, 150);  rq.ptype = 7; send_req(rq);
        rq = span_req(ACT_ADD_PRES, 0, 100);   rq.ptype = 7; send_req(rq);
        send_req(span_req(ACT_ADD_STYLE, 150, 250));
        rq = span_req(ACT_READ, 0, 0);            rq.index = 5'd31; send_req(rq);
        for (n = 5; n <= 7; n++)
            send_req(span_req(3'(n), 0, 0));
        rq = span_req(ACT_QUERY, 0, 0);  rq.qpos = 150; send_req(rq);
        rq = span_req(ACT_QUERY, 0, 0);  rq.qpos = 50;  send_req(rq);

        // Random: regions move on each clear, so high offsets are covered too
        for (n = 0; n < 330; n++) begin
            calm = (n >= 180 && n < 260);
            if (n == 150) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            rq = random_req();
            if (rq.action == ACT_CLEAR) begin
                case ($urandom_range(0, 2))
                    0: region = 0;
                    1: region = 32'hFFFF_F000;
                    default: region = $urandom & 32'hFFFF_0000;
                endcase
            end
            send_req(rq);
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Sent %0d requests (adds, merges, reads, queries, clears, bad codes);",
                 sent);
        $display("checked %0d results against the predicted table.", results);
        if (errors == 0 && pending == 0)
            $display("PASS sorted_disjoint_span_table");
        else
            $display("FAIL sorted_disjoint_span_table");
        $finish;
    end

endmodule

### sorted_disjoint_span_table.f
hdl/sdst_pkg.sv
hdl/sdst_mem.sv
hdl/sdst_out.sv
hdl/sdst_ctrl.sv
hdl/sorted_disjoint_span_table.sv
tb/sorted_disjoint_span_table_check.sv
tb/sorted_disjoint_span_table_test.sv
